// File: hw/rtl/dspc_pkg.sv
// ----------------------------------------------------------------------------
// dspc_pkg: shared types and constants for the setpoint compare unit
// Register map, reset values, field widths, the compare map scaling and the
// step size rule used by the key logic.
// ----------------------------------------------------------------------------
package dspc_pkg;

   localparam int DEBOUNCE_SAMPLES = 16;

   localparam int MV_W       = 16;
   localparam int COUNT_W    = 16;
   localparam int CMP_W      = 16;
   localparam int OFFSET_W   = 32;
   localparam int STEP_W     = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register index, taken from the word address
   typedef enum logic [2:0] {
      REG_MAX_TARGET_MV = 3'd0,
      REG_REPEAT_AFTER  = 3'd1,
      REG_FAST_AFTER    = 3'd2,
      REG_KNEE_MV       = 3'd3,
      REG_SLOPE_LOW     = 3'd4,
      REG_OFFSET_LOW    = 3'd5,
      REG_SLOPE_HIGH    = 3'd6,
      REG_OFFSET_HIGH   = 3'd7
   } reg_index_type;

   localparam logic [MV_W-1:0]           RST_MAX_TARGET_MV = 16'd2000;
   localparam logic [COUNT_W-1:0]        RST_REPEAT_AFTER  = 16'd300;
   localparam logic [COUNT_W-1:0]        RST_FAST_AFTER    = 16'd1000;
   localparam logic [MV_W-1:0]           RST_KNEE_MV       = 16'd500;
   localparam logic [15:0]               RST_SLOPE_LOW     = 16'd15400;
   localparam logic signed [OFFSET_W-1:0] RST_OFFSET_LOW   = -32'sd20000;
   localparam logic [15:0]               RST_SLOPE_HIGH    = 16'd15326;
   localparam logic signed [OFFSET_W-1:0] RST_OFFSET_HIGH  = 32'sd26670;
   localparam logic [MV_W-1:0]           RST_TARGET_MV     = 16'd200;

   localparam logic [STEP_W-1:0] STEP_NONE = 4'd0;
   localparam logic [STEP_W-1:0] STEP_FINE = 4'd1;
   localparam logic [STEP_W-1:0] STEP_FAST = 4'd10;

   // compare map: (slope * mv + offset) / MAP_SCALE, saturated to CMP_W bits
   localparam longint MAP_SCALE   = 10000;
   localparam int     SUM_W       = 34;
   localparam int     REM_W       = 30;
   localparam int     PROD_W      = 32;
   localparam int     RECIP_SHIFT = 43;
   localparam longint RECIP_MULT  = ((longint'(1) << RECIP_SHIFT) + MAP_SCALE - 1) / MAP_SCALE;
   localparam longint SAT_SUM     = (longint'(1) << CMP_W) * MAP_SCALE;

   typedef struct packed {
      logic [MV_W-1:0]            knee_mv;
      logic [15:0]                slope_low;
      logic signed [OFFSET_W-1:0] offset_low;
      logic [15:0]                slope_high;
      logic signed [OFFSET_W-1:0] offset_high;
   } map_cfg_type;

   // step for a held key, from its hold count before this tick
   function automatic logic [STEP_W-1:0] step_size(
      input logic [COUNT_W-1:0] count,
      input logic [COUNT_W-1:0] repeat_after,
      input logic [COUNT_W-1:0] fast_after
   );
      logic [STEP_W-1:0] step;
      if (count == '0) begin
         step = STEP_FINE;
      end else if (count > fast_after) begin
         step = STEP_FAST;
      end else if (count > repeat_after) begin
         step = STEP_FINE;
      end else begin
         step = STEP_NONE;
      end
      return step;
   endfunction

endpackage

// File: hw/rtl/dspc_map.sv
// ----------------------------------------------------------------------------
// dspc_map: pipelined two-segment linear map to a PWM compare value
// Segment select and multiply, offset add and range check, reciprocal
// multiply for the divide by the scale, then saturate into the output register.
// ----------------------------------------------------------------------------
module dspc_map (
   input  logic                         clock,
   input  logic                         reset,
   input  dspc_pkg::map_cfg_type        cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [dspc_pkg::MV_W-1:0]    in_mv,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [dspc_pkg::MV_W-1:0]    out_target_mv,
   output logic [dspc_pkg::CMP_W-1:0]   out_compare
);

   localparam int MV_W   = dspc_pkg::MV_W;
   localparam int CMP_W  = dspc_pkg::CMP_W;
   localparam int SUM_W  = dspc_pkg::SUM_W;
   localparam int REM_W  = dspc_pkg::REM_W;
   localparam int PROD_W = dspc_pkg::PROD_W;
   localparam int OFF_W  = dspc_pkg::OFFSET_W;
   localparam int QP_W   = 2 * REM_W;
   localparam logic [REM_W-1:0]   RECIP = REM_W'(dspc_pkg::RECIP_MULT);
   localparam logic [SUM_W-2:0]   SAT   = (SUM_W-1)'(dspc_pkg::SAT_SUM);

   // stage loads, from the output backwards
   logic out_ld, s4_ld, s3_ld, s2_ld, s1_ld;

   logic                    s1_valid_ff;
   logic [MV_W-1:0]         s1_mv_ff;
   logic                    s2_valid_ff;
   logic [MV_W-1:0]         s2_mv_ff;
   logic [PROD_W-1:0]       s2_prod_ff, s2_prod_in;
   logic signed [OFF_W-1:0] s2_offset_ff, s2_offset_in;
   logic                    s3_valid_ff;
   logic [MV_W-1:0]         s3_mv_ff;
   logic                    s3_neg_ff, s3_neg_in;
   logic                    s3_sat_ff, s3_sat_in;
   logic [REM_W-1:0]        s3_rem_ff;
   logic                    s4_valid_ff;
   logic [MV_W-1:0]         s4_mv_ff;
   logic                    s4_neg_ff, s4_sat_ff;
   logic [QP_W-1:0]         s4_qprod_ff, s4_qprod_in;
   logic                    out_valid_ff;
   logic [MV_W-1:0]         out_mv_ff;
   logic [CMP_W-1:0]        out_cmp_ff, out_cmp_in;

   logic [15:0]             slope_sel;
   logic signed [SUM_W-1:0] sum;

   assign out_ld   = !out_valid_ff || out_ready;
   assign s4_ld    = !s4_valid_ff || out_ld;
   assign s3_ld    = !s3_valid_ff || s4_ld;
   assign s2_ld    = !s2_valid_ff || s3_ld;
   assign s1_ld    = !s1_valid_ff || s2_ld;
   assign in_ready = s1_ld;

   always_comb begin
      if (s1_mv_ff <= cfg.knee_mv) begin
         slope_sel    = cfg.slope_low;
         s2_offset_in = cfg.offset_low;
      end else begin
         slope_sel    = cfg.slope_high;
         s2_offset_in = cfg.offset_high;
      end
      s2_prod_in = {16'b0, slope_sel} * {16'b0, s1_mv_ff};

      sum = $signed({2'b00, s2_prod_ff}) + $signed({{2{s2_offset_ff[OFF_W-1]}}, s2_offset_ff});
      s3_neg_in = sum[SUM_W-1];
      s3_sat_in = !sum[SUM_W-1] && (sum[SUM_W-2:0] >= SAT);

      s4_qprod_in = {{REM_W{1'b0}}, s3_rem_ff} * {{REM_W{1'b0}}, RECIP};

      if (s4_neg_ff) begin
         out_cmp_in = '0;
      end else if (s4_sat_ff) begin
         out_cmp_in = '1;
      end else begin
         out_cmp_in = s4_qprod_ff[dspc_pkg::RECIP_SHIFT +: CMP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ld)  s1_valid_ff  <= in_valid;
         if (s2_ld)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ld)  s3_valid_ff  <= s2_valid_ff;
         if (s4_ld)  s4_valid_ff  <= s3_valid_ff;
         if (out_ld) out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ld && in_valid) begin
         s1_mv_ff <= in_mv;
      end
      if (s2_ld && s1_valid_ff) begin
         s2_mv_ff     <= s1_mv_ff;
         s2_prod_ff   <= s2_prod_in;
         s2_offset_ff <= s2_offset_in;
      end
      if (s3_ld && s2_valid_ff) begin
         s3_mv_ff  <= s2_mv_ff;
         s3_neg_ff <= s3_neg_in;
         s3_sat_ff <= s3_sat_in;
         s3_rem_ff <= sum[REM_W-1:0];
      end
      if (s4_ld && s3_valid_ff) begin
         s4_mv_ff    <= s3_mv_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_sat_ff   <= s3_sat_ff;
         s4_qprod_ff <= s4_qprod_in;
      end
      if (out_ld && s4_valid_ff) begin
         out_mv_ff  <= s4_mv_ff;
         out_cmp_ff <= out_cmp_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_target_mv = out_mv_ff;
   assign out_compare   = out_cmp_ff;

endmodule

// File: hw/rtl/debounced_setpoint_to_pwm_compare_unit.sv
// ----------------------------------------------------------------------------
// debounced_setpoint_to_pwm_compare_unit: key debounce, setpoint and PWM map
// Debounces an up and a down key, steps a millivolt target with auto repeat
// and maps the target to a PWM compare value through two linear segments.
// ----------------------------------------------------------------------------
// A result passes the map registers s1 to s4 and then the output register.
// Throughput: one request per cycle while results are taken; key state updates
// in the accept cycle; the map is a five-register pipeline with per-stage flow control.
// Reset (synchronous, active high) clears histories and hold counts, sets the
// target to 200 mV, loads register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module debounced_setpoint_to_pwm_compare_unit #(
   parameter int DEBOUNCE_SAMPLES = dspc_pkg::DEBOUNCE_SAMPLES
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: [0] up_pressed, [1] down_pressed, [7:2] zero
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,
   // result: [15:0] target_mv, [31:16] compare_value
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dspc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dspc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dspc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int N       = DEBOUNCE_SAMPLES;
   localparam int MV_W    = dspc_pkg::MV_W;
   localparam int COUNT_W = dspc_pkg::COUNT_W;
   localparam int STEP_W  = dspc_pkg::STEP_W;
   localparam int OFF_W   = dspc_pkg::OFFSET_W;
   localparam int DATA_W  = dspc_pkg::CSR_DATA_W;
   localparam int T_W     = MV_W + 2;   // room for carry and borrow
   localparam int CSR_ADDR_W_HI = dspc_pkg::CSR_ADDR_W - 1;

   // ---------------------------------------------------------------- registers
   logic [MV_W-1:0]         max_target_ff;
   logic [COUNT_W-1:0]      repeat_after_ff;
   logic [COUNT_W-1:0]      fast_after_ff;
   logic [MV_W-1:0]         knee_ff;
   logic [15:0]             slope_low_ff;
   logic signed [OFF_W-1:0] offset_low_ff;
   logic [15:0]             slope_high_ff;
   logic signed [OFF_W-1:0] offset_high_ff;

   dspc_pkg::reg_index_type csr_index;
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = dspc_pkg::reg_index_type'(csr_paddr[CSR_ADDR_W_HI:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_target_ff   <= dspc_pkg::RST_MAX_TARGET_MV;
         repeat_after_ff <= dspc_pkg::RST_REPEAT_AFTER;
         fast_after_ff   <= dspc_pkg::RST_FAST_AFTER;
         knee_ff         <= dspc_pkg::RST_KNEE_MV;
         slope_low_ff    <= dspc_pkg::RST_SLOPE_LOW;
         offset_low_ff   <= dspc_pkg::RST_OFFSET_LOW;
         slope_high_ff   <= dspc_pkg::RST_SLOPE_HIGH;
         offset_high_ff  <= dspc_pkg::RST_OFFSET_HIGH;
      end else if (csr_write) begin
         case (csr_index)
            dspc_pkg::REG_MAX_TARGET_MV: max_target_ff   <= csr_pwdata[MV_W-1:0];
            dspc_pkg::REG_REPEAT_AFTER:  repeat_after_ff <= csr_pwdata[COUNT_W-1:0];
            dspc_pkg::REG_FAST_AFTER:    fast_after_ff   <= csr_pwdata[COUNT_W-1:0];
            dspc_pkg::REG_KNEE_MV:       knee_ff         <= csr_pwdata[MV_W-1:0];
            dspc_pkg::REG_SLOPE_LOW:     slope_low_ff    <= csr_pwdata[15:0];
            dspc_pkg::REG_OFFSET_LOW:    offset_low_ff   <= $signed(csr_pwdata[OFF_W-1:0]);
            dspc_pkg::REG_SLOPE_HIGH:    slope_high_ff   <= csr_pwdata[15:0];
            dspc_pkg::REG_OFFSET_HIGH:   offset_high_ff  <= $signed(csr_pwdata[OFF_W-1:0]);
            default: ;
         endcase
      end
   end

   // read back, 16-bit registers zero extended
   always_comb begin
      case (csr_index)
         dspc_pkg::REG_MAX_TARGET_MV: csr_prdata = DATA_W'(max_target_ff);
         dspc_pkg::REG_REPEAT_AFTER:  csr_prdata = DATA_W'(repeat_after_ff);
         dspc_pkg::REG_FAST_AFTER:    csr_prdata = DATA_W'(fast_after_ff);
         dspc_pkg::REG_KNEE_MV:       csr_prdata = DATA_W'(knee_ff);
         dspc_pkg::REG_SLOPE_LOW:     csr_prdata = DATA_W'(slope_low_ff);
         dspc_pkg::REG_OFFSET_LOW:    csr_prdata = DATA_W'(offset_low_ff);
         dspc_pkg::REG_SLOPE_HIGH:    csr_prdata = DATA_W'(slope_high_ff);
         dspc_pkg::REG_OFFSET_HIGH:   csr_prdata = DATA_W'(offset_high_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- key state
   logic [N-1:0]       up_hist_ff, up_hist_in;
   logic [N-1:0]       dn_hist_ff, dn_hist_in;
   logic [COUNT_W-1:0] up_count_ff, up_count_in;
   logic [COUNT_W-1:0] dn_count_ff, dn_count_in;
   logic [MV_W-1:0]    target_ff, target_in;

   logic               req_accept;
   logic               up_held, dn_held;
   logic [STEP_W-1:0]  up_step, dn_step;
   logic [T_W-1:0]     up_sum, dn_diff;
   logic [MV_W-1:0]    target_after_up;
   logic               map_ready;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = map_ready;

   always_comb begin
      // shift in the new samples; a key is held when its whole history is set
      up_hist_in = {up_hist_ff[N-2:0], req_tdata[0]};
      dn_hist_in = {dn_hist_ff[N-2:0], req_tdata[1]};
      up_held    = &up_hist_in;
      dn_held    = &dn_hist_in;

      up_step = dspc_pkg::step_size(up_count_ff, repeat_after_ff, fast_after_ff);
      dn_step = dspc_pkg::step_size(dn_count_ff, repeat_after_ff, fast_after_ff);

      // up first: step and clamp to the maximum
      up_sum = {2'b00, target_ff} + T_W'(up_step);
      if (!up_held) begin
         target_after_up = target_ff;
      end else if (up_sum > {2'b00, max_target_ff}) begin
         target_after_up = max_target_ff;
      end else begin
         target_after_up = up_sum[MV_W-1:0];
      end

      // then down: a borrow clamps to zero, a lowered maximum still clamps
      dn_diff = {2'b00, target_after_up} - T_W'(dn_step);
      if (!dn_held) begin
         target_in = target_after_up;
      end else if (dn_diff[T_W-1]) begin
         target_in = '0;
      end else if (dn_diff > {2'b00, max_target_ff}) begin
         target_in = max_target_ff;
      end else begin
         target_in = dn_diff[MV_W-1:0];
      end

      // hold counters saturate while held and drop to zero on release
      if (!up_held) begin
         up_count_in = '0;
      end else if (&up_count_ff) begin
         up_count_in = up_count_ff;
      end else begin
         up_count_in = up_count_ff + 1'b1;
      end
      if (!dn_held) begin
         dn_count_in = '0;
      end else if (&dn_count_ff) begin
         dn_count_in = dn_count_ff;
      end else begin
         dn_count_in = dn_count_ff + 1'b1;
      end
   end

   // advance the key state only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         up_hist_ff  <= '0;
         dn_hist_ff  <= '0;
         up_count_ff <= '0;
         dn_count_ff <= '0;
         target_ff   <= dspc_pkg::RST_TARGET_MV;
      end else if (req_accept) begin
         up_hist_ff  <= up_hist_in;
         dn_hist_ff  <= dn_hist_in;
         up_count_ff <= up_count_in;
         dn_count_ff <= dn_count_in;
         target_ff   <= target_in;
      end
   end

   // ---------------------------------------------------------------- compare map
   dspc_pkg::map_cfg_type map_cfg;
   logic [MV_W-1:0]            rsp_target;
   logic [dspc_pkg::CMP_W-1:0] rsp_compare;

   assign map_cfg.knee_mv     = knee_ff;
   assign map_cfg.slope_low   = slope_low_ff;
   assign map_cfg.offset_low  = offset_low_ff;
   assign map_cfg.slope_high  = slope_high_ff;
   assign map_cfg.offset_high = offset_high_ff;

   // the new target enters the map pipeline with its request
   dspc_map u_map (
      .clock         (clock),
      .reset         (reset),
      .cfg           (map_cfg),
      .in_valid      (req_tvalid),
      .in_ready      (map_ready),
      .in_mv         (target_in),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_target_mv (rsp_target),
      .out_compare   (rsp_compare)
   );

   assign rsp_tdata = {rsp_compare, rsp_target};

endmodule

// File: hw/rtl/dspc_checker.sv
// ----------------------------------------------------------------------------
// dspc_checker: port-level checks for the setpoint compare unit
// Watches the request, result and register ports over time.
// ----------------------------------------------------------------------------
module dspc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [7:0]                        req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [31:0]                       rsp_tdata,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [dspc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [dspc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [dspc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                              csr_pready
);

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // with no result waiting, the pipeline always takes a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

   // the low 16 bits of a written register read back on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(csr_wr) && csr_psel && !csr_pwrite
         && csr_paddr == $past(csr_paddr))
      |-> csr_prdata[15:0] == $past(csr_pwdata[15:0]))
      else $error("register read back mismatch");

endmodule

bind debounced_setpoint_to_pwm_compare_unit dspc_checker u_dspc_checker (.*);
